>>> rtl/lpfr_pkg.sv
// Shared widths, codes and state encoding for the length-prefixed frame receiver.
`default_nettype none

package lpfr_pkg;

	localparam int DATA_W = 8;
	localparam int IDX_W  = 5;
	localparam int FLEN_W = 6;
	localparam int TICK_W = 8;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 8'hFF;
	localparam logic [TICK_W-1:0] TICK_SAT    = 8'hFF;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_WAIT  = 3'b001,
		ST_RECV  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

endpackage

`default_nettype wire

>>> rtl/lpfr_if.sv
// Valid/ready channel interfaces: input items, frame bytes out and timeout configuration.
`default_nettype none

interface lpfr_in_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [lpfr_pkg::DATA_W-1:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface lpfr_out_if;
	logic                        valid;
	logic                        ready;
	logic [lpfr_pkg::DATA_W-1:0] data;
	logic [lpfr_pkg::IDX_W-1:0]  index;
	logic [lpfr_pkg::FLEN_W-1:0] frame_length;
	logic                        last;

	modport source (output valid, output data, output index, output frame_length,
		output last, input ready);
	modport sink   (input valid, input data, input index, input frame_length,
		input last, output ready);
endinterface

interface lpfr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lpfr_pkg::TICK_W-1:0] timeout_ticks;

	modport source (output valid, output timeout_ticks, input ready);
	modport sink   (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

>>> rtl/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver: frame buffer memory, receive control and drain.
//
// Channels: item (sink) carries received bytes (op = 0) and timer ticks (op = 1);
// result (source) carries one transaction per payload byte of a completed frame,
// with index, frame_length and last; cfg (sink) writes timeout_ticks, always ready.
// While waiting, a byte from 1 to FRAME_MAX opens a frame of that length. Each
// frame byte is written into the frame buffer, one item per cycle. A partial frame
// is dropped once timeout_ticks ticks arrive with no byte between them.
// The byte that completes a frame of L bytes is followed by a drain of L buffer
// reads, one per cycle while result is not stalled, through the single read port;
// the read data register is the output register. item.ready is low during the
// drain, so no new item is taken before the last read. The first result appears
// once the drain state is registered and its first read loads the output register.
// When result is stalled the drain holds; once the last read is issued, new items
// are taken while the final byte still waits in the output register.
// Reset clears the control state, the timeout to 255 and the output valid; the
// buffer contents are not cleared, as only bytes of the current frame are read.
`default_nettype none

module length_prefixed_frame_receiver #(
	parameter int FRAME_MAX = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	lpfr_in_if.sink      item,
	lpfr_out_if.source   result,
	lpfr_cfg_if.sink     cfg
);

	localparam int CW    = $clog2(FRAME_MAX + 1);
	localparam int AW    = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
	localparam int EXT_W = (CW > lpfr_pkg::FLEN_W) ? CW : lpfr_pkg::FLEN_W;

	lpfr_pkg::state_t state_q;

	logic [lpfr_pkg::TICK_W-1:0] timeout_q;
	logic [lpfr_pkg::TICK_W-1:0] idle_q;
	logic [lpfr_pkg::TICK_W-1:0] idle_inc;
	logic [CW-1:0]               len_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               cnt_inc;
	logic [CW-1:0]               rd_k_q;
	logic [CW-1:0]               len_m1;
	logic                        out_valid_q;

	logic [lpfr_pkg::DATA_W-1:0] mem [FRAME_MAX];
	logic [lpfr_pkg::DATA_W-1:0] data_q;
	logic [lpfr_pkg::IDX_W-1:0]  index_q;
	logic [lpfr_pkg::FLEN_W-1:0] flen_q;
	logic                        last_q;

	logic            item_fire;
	logic            out_fire;
	logic            adv;
	logic            len_ok;
	logic            wr_en;
	logic            rd_en;
	logic [EXT_W-1:0] len_ext;
	logic [EXT_W-1:0] idx_ext;

	assign item.ready = (state_q == lpfr_pkg::ST_WAIT) || (state_q == lpfr_pkg::ST_RECV);
	assign cfg.ready  = 1'b1;
	assign item_fire  = item.valid && item.ready;
	assign out_fire   = out_valid_q && result.ready;
	assign adv        = !out_valid_q || result.ready;

	assign len_ok   = (item.rx_byte != '0) &&
		(item.rx_byte <= lpfr_pkg::DATA_W'(FRAME_MAX));
	assign idle_inc = (idle_q == lpfr_pkg::TICK_SAT) ? idle_q : idle_q + 8'd1;
	assign cnt_inc  = cnt_q + CW'(1);
	assign len_m1   = len_q - CW'(1);

	assign wr_en = item_fire && (state_q == lpfr_pkg::ST_RECV) &&
		(item.op == lpfr_pkg::OP_BYTE);
	assign rd_en = (state_q == lpfr_pkg::ST_DRAIN) && adv;

	assign len_ext = EXT_W'(len_q);
	assign idx_ext = EXT_W'(rd_k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= lpfr_pkg::TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			timeout_q <= cfg.timeout_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpfr_pkg::ST_WAIT;
			len_q       <= '0;
			cnt_q       <= '0;
			idle_q      <= '0;
			rd_k_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lpfr_pkg::ST_WAIT: begin
					if (item_fire && (item.op == lpfr_pkg::OP_BYTE) && len_ok) begin
						len_q   <= CW'(item.rx_byte);
						cnt_q   <= '0;
						idle_q  <= '0;
						state_q <= lpfr_pkg::ST_RECV;
					end
				end
				lpfr_pkg::ST_RECV: begin
					if (item_fire) begin
						if (item.op == lpfr_pkg::OP_TICK) begin
							if (idle_inc >= timeout_q) begin
								state_q <= lpfr_pkg::ST_WAIT;
								len_q   <= '0;
								cnt_q   <= '0;
								idle_q  <= '0;
							end else begin
								idle_q <= idle_inc;
							end
						end else begin
							idle_q <= '0;
							cnt_q  <= cnt_inc;
							if (cnt_inc == len_q) begin
								rd_k_q  <= '0;
								state_q <= lpfr_pkg::ST_DRAIN;
							end
						end
					end
				end
				lpfr_pkg::ST_DRAIN: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						rd_k_q      <= rd_k_q + CW'(1);
						if (rd_k_q == len_m1) begin
							state_q <= lpfr_pkg::ST_WAIT;
							len_q   <= '0;
							cnt_q   <= '0;
							idle_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= lpfr_pkg::ST_WAIT;
				end
			endcase
		end
	end

	// Frame buffer: write while receiving, read while draining; never both.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[AW-1:0]] <= item.rx_byte;
		end
		if (rd_en) begin
			data_q  <= mem[rd_k_q[AW-1:0]];
			index_q <= idx_ext[lpfr_pkg::IDX_W-1:0];
			flen_q  <= len_ext[lpfr_pkg::FLEN_W-1:0];
			last_q  <= (rd_k_q == len_m1);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.data         = data_q;
	assign result.index        = index_q;
	assign result.frame_length = flen_q;
	assign result.last         = last_q;

`ifndef SYNTHESIS
	a_recv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpfr_pkg::ST_RECV) |-> (cnt_q < len_q))
		else $error("byte count reached frame length while receiving");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpfr_pkg::ST_DRAIN) |-> (rd_k_q < len_q))
		else $error("drain read beyond frame length");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("frame buffer written and read in one cycle");

	a_read_shows: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> result.valid)
		else $error("buffer read not presented on result");
`endif

endmodule

`default_nettype wire
